FILE: rtl/core/vaubf_pkg.sv
package vaubf_pkg;

    localparam int OFFSET_W = 24;
    localparam int MaxSearchBytes = 16777216;
    localparam logic [OFFSET_W-1:0] OFFSET_CAP =
        (MaxSearchBytes - 1 > 24'hFFFFFF) ? 24'hFFFFFF : OFFSET_W'(MaxSearchBytes - 1);

    localparam logic [4:0] AVC_ROOM_BYTES  = 5'd16;
    localparam logic [4:0] HEVC_ROOM_BYTES = 5'd4;

    localparam logic [5:0] AVC_NAL_EOS  = 6'd11;
    localparam logic [5:0] HEVC_NAL_EOS = 6'd37;

    typedef enum logic [1:0] {
        STATUS_BOUNDARY  = 2'd0,
        STATUS_EOS_FIRST = 2'd1,
        STATUS_NEED_ROOM = 2'd2,
        STATUS_NEED_TAIL = 2'd3
    } status_t;

endpackage

FILE: rtl/core/video_access_unit_boundary_finder.sv
// Annex B access unit boundary finder for H.264 and H.265 byte streams.
// Input channel (in_valid/in_ready) carries one stream byte per beat with
// search_start marking offset 0 of a new search and buffer_end marking the
// last byte available. Output channel (out_valid/out_ready) carries at most
// one result per search: status, unit_offset and first_nal_type.
// cfg_wr_en/cfg_wr_data write codec_mode (0 H.264, 1 H.265).
// A byte's result is shown in the cycle after that byte is accepted. One
// byte is taken per cycle while no result is held; the whole per-byte
// update is a single register-to-register step feeding one output register.
// When the receiver stalls with a result held, in_ready drops until the
// result is taken; bytes that cause no result still flow while no result
// waits. Bytes arriving after a result and before the next search_start are
// accepted and dropped. Reset clears the search (waiting for search_start),
// empties the output register and sets codec_mode to H.264.
// Offsets saturate at the 24-bit limit.
module video_access_unit_boundary_finder (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_wr_en,
    input  logic        cfg_wr_data,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [7:0]  data_byte,
    input  logic        search_start,
    input  logic        buffer_end,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [1:0]  status,
    output logic [23:0] unit_offset,
    output logic [5:0]  first_nal_type
);
    import vaubf_pkg::*;

    typedef enum logic [3:0] {
        PH_SEEK  = 4'b0001,
        PH_ZERO1 = 4'b0010,
        PH_ZERO2 = 4'b0100,
        PH_HDR   = 4'b1000
    } phase_t;

    logic                codec_mode_reg;
    phase_t              phase_reg, phase_next;
    logic                header_seen_reg, header_seen_next;
    logic [OFFSET_W-1:0] pos_reg, pos_next;
    logic [3:0]          zero_hist_reg, zero_hist_next;
    logic [5:0]          saved_nal_reg, saved_nal_next;
    logic [4:0]          room_reg, room_next;
    logic [4:0]          hdr_room_reg, hdr_room_next;
    logic [1:0]          look_reg, look_next;
    logic [OFFSET_W-1:0] pend_off_reg, pend_off_next;
    logic                pend_bnd_reg, pend_bnd_next;
    logic                done_reg, done_next;

    logic                out_valid_reg;
    status_t             status_reg, status_next;
    logic [OFFSET_W-1:0] offset_reg, offset_next;
    logic [5:0]          nal_reg, nal_next;

    logic                accept;
    logic                active;
    logic                res_valid;
    logic                eos_first;
    logic                scan;
    logic [5:0]          hdr_type;

    function automatic logic [OFFSET_W-1:0] start_code_offset(
        input logic [OFFSET_W-1:0] p,
        input logic                zero4
    );
        logic [OFFSET_W-1:0] r;
        if (p >= OFFSET_CAP)
            r = OFFSET_CAP;
        else if (p > OFFSET_W'(4) && zero4)
            r = p - OFFSET_W'(4);
        else if (p < OFFSET_W'(3))
            r = '0;
        else
            r = p - OFFSET_W'(3);
        return r;
    endfunction

    assign in_ready = !out_valid_reg || out_ready;
    assign accept   = in_valid && in_ready;
    assign active   = search_start || !done_reg;

    always_comb
    begin
        // start from the current search, or a cleared one on search_start
        phase_next       = search_start ? PH_SEEK : phase_reg;
        header_seen_next = search_start ? 1'b0 : header_seen_reg;
        pos_next         = search_start ? '0 : pos_reg;
        zero_hist_next   = search_start ? 4'b1111 : zero_hist_reg;
        saved_nal_next   = search_start ? 6'd0 : saved_nal_reg;
        room_next        = search_start ? 5'd0 : room_reg;
        hdr_room_next    = search_start ? 5'd0 : hdr_room_reg;
        look_next        = search_start ? 2'd0 : look_reg;
        pend_off_next    = search_start ? '0 : pend_off_reg;
        pend_bnd_next    = search_start ? 1'b0 : pend_bnd_reg;
        done_next        = done_reg;
        eos_first        = 1'b0;
        scan             = 1'b0;
        res_valid        = 1'b0;
        status_next      = STATUS_BOUNDARY;
        offset_next      = '0;
        nal_next         = '0;
        hdr_type         = codec_mode_reg ? data_byte[6:1] : {1'b0, data_byte[4:0]};

        if (room_next != 5'd0)
            room_next = room_next - 5'd1;
        if (hdr_room_next != 5'd0)
            hdr_room_next = hdr_room_next - 5'd1;

        if (!pend_bnd_next)
        begin
            scan = 1'b1;
            if (look_next != 2'd0)
            begin
                look_next = look_next - 2'd1;
                // first_mb / first_slice_segment bit set: new picture
                if (look_next == 2'd0 && data_byte[7])
                begin
                    pend_bnd_next = 1'b1;
                    scan          = 1'b0;
                end
            end
        end

        if (scan)
        begin
            unique case (phase_next)
                PH_SEEK:
                begin
                    if (data_byte == 8'h00)
                        phase_next = PH_ZERO1;
                end
                PH_ZERO1:
                begin
                    phase_next = (data_byte == 8'h00) ? PH_ZERO2 : PH_SEEK;
                end
                PH_ZERO2:
                begin
                    if (data_byte == 8'h01)
                        phase_next = PH_HDR;
                    else if (data_byte != 8'h00)
                        phase_next = PH_SEEK;
                end
                PH_HDR:
                begin
                    phase_next = PH_SEEK;
                    if (( codec_mode_reg && hdr_type == HEVC_NAL_EOS) ||
                        (!codec_mode_reg && hdr_type == AVC_NAL_EOS))
                    begin
                        if (!header_seen_next)
                        begin
                            saved_nal_next = hdr_type;
                            pend_off_next  = (pos_next >= OFFSET_CAP) ? OFFSET_CAP
                                                                      : pos_next + OFFSET_W'(1);
                            eos_first      = 1'b1;
                        end
                        else
                        begin
                            pend_off_next = start_code_offset(pos_next, zero_hist_next[3]);
                            pend_bnd_next = 1'b1;
                        end
                    end
                    else if (codec_mode_reg)
                    begin
                        if (hdr_type >= 6'd32)
                        begin
                            if (header_seen_next)
                            begin
                                pend_off_next = start_code_offset(pos_next,
                                                                  zero_hist_next[3]);
                                pend_bnd_next = 1'b1;
                            end
                        end
                        else if (!header_seen_next)
                        begin
                            saved_nal_next   = hdr_type;
                            header_seen_next = 1'b1;
                        end
                        else
                        begin
                            if (room_next < HEVC_ROOM_BYTES)
                                room_next = HEVC_ROOM_BYTES;
                            look_next     = 2'd2;
                            pend_off_next = start_code_offset(pos_next, zero_hist_next[3]);
                        end
                    end
                    else if (data_byte == 8'h00)
                    begin
                        // a zero header byte opens a new start code
                        phase_next = PH_ZERO1;
                    end
                    else if (hdr_type >= 6'd1 && hdr_type <= 6'd5)
                    begin
                        if (room_next < AVC_ROOM_BYTES)
                            room_next = AVC_ROOM_BYTES;
                        if (header_seen_next)
                        begin
                            look_next     = 2'd1;
                            pend_off_next = start_code_offset(pos_next, zero_hist_next[3]);
                        end
                        else
                        begin
                            saved_nal_next   = hdr_type;
                            header_seen_next = 1'b1;
                            hdr_room_next    = AVC_ROOM_BYTES;
                        end
                    end
                    else if (hdr_type >= 6'd6 && hdr_type <= 6'd10)
                    begin
                        if (header_seen_next)
                        begin
                            pend_off_next = start_code_offset(pos_next, zero_hist_next[3]);
                            pend_bnd_next = 1'b1;
                        end
                    end
                end
                default:
                begin
                    phase_next = PH_SEEK;
                end
            endcase
        end

        zero_hist_next = {zero_hist_next[2:0], data_byte == 8'h00};
        if (pos_next < OFFSET_CAP)
            pos_next = pos_next + OFFSET_W'(1);

        nal_next = saved_nal_next;
        priority if (eos_first)
        begin
            res_valid   = 1'b1;
            status_next = STATUS_EOS_FIRST;
            offset_next = pend_off_next;
        end
        else if (pend_bnd_next && room_next == 5'd0)
        begin
            res_valid   = 1'b1;
            status_next = STATUS_BOUNDARY;
            offset_next = pend_off_next;
        end
        else if (buffer_end)
        begin
            res_valid = 1'b1;
            if (room_next != 5'd0)
            begin
                status_next = STATUS_NEED_ROOM;
                if (hdr_room_next != 5'd0)
                    nal_next = '0;
            end
            else
            begin
                status_next = STATUS_NEED_TAIL;
            end
        end
        done_next = res_valid;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            codec_mode_reg  <= 1'b0;
            phase_reg       <= PH_SEEK;
            header_seen_reg <= 1'b0;
            pos_reg         <= '0;
            zero_hist_reg   <= 4'b1111;
            saved_nal_reg   <= '0;
            room_reg        <= '0;
            hdr_room_reg    <= '0;
            look_reg        <= '0;
            pend_off_reg    <= '0;
            pend_bnd_reg    <= 1'b0;
            done_reg        <= 1'b1;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            if (cfg_wr_en)
                codec_mode_reg <= cfg_wr_data;
            // drop bytes while no search is open
            if (accept && active)
            begin
                phase_reg       <= phase_next;
                header_seen_reg <= header_seen_next;
                pos_reg         <= pos_next;
                zero_hist_reg   <= zero_hist_next;
                saved_nal_reg   <= saved_nal_next;
                room_reg        <= room_next;
                hdr_room_reg    <= hdr_room_next;
                look_reg        <= look_next;
                pend_off_reg    <= pend_off_next;
                pend_bnd_reg    <= pend_bnd_next;
                done_reg        <= done_next;
            end
            if (accept && active && res_valid)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept && active && res_valid)
        begin
            status_reg <= status_next;
            offset_reg <= offset_next;
            nal_reg    <= nal_next;
        end
    end

    assign out_valid      = out_valid_reg;
    assign status         = status_reg;
    assign unit_offset    = offset_reg;
    assign first_nal_type = nal_reg;

endmodule

FILE: rtl/core/vaubf_checker.sv
module vaubf_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        in_valid,
    input logic        in_ready,
    input logic        out_valid,
    input logic        out_ready,
    input logic [1:0]  status,
    input logic [23:0] unit_offset,
    input logic [5:0]  first_nal_type
);
    import vaubf_pkg::*;

    // a held result must keep its beat until taken
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(status) &&
            $stable(unit_offset) && $stable(first_nal_type))
        else $error("result beat changed while stalled");

    a_stall_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |-> !in_ready)
        else $error("input taken while a result is held");

    a_result_from_beat: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(in_valid && in_ready))
        else $error("result without an accepted input beat");

    a_need_more_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (status == STATUS_NEED_ROOM || status == STATUS_NEED_TAIL)
            |-> unit_offset == 24'd0)
        else $error("need-more-data result carries an offset");

endmodule

bind video_access_unit_boundary_finder vaubf_checker u_vaubf_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .status         (status),
    .unit_offset    (unit_offset),
    .first_nal_type (first_nal_type)
);
